@@ hdl/i2cm_pkg.sv @@
// I2C master byte engine: shared types and constants.
// Item structs, command codes, phase encoding and the config bundle.
// No dependencies.
`default_nettype none

package i2cm_pkg;

  localparam int unsigned CmdW = 3;

  localparam logic [CmdW-1:0] CMD_NONE  = 3'd0;
  localparam logic [CmdW-1:0] CMD_WAKE  = 3'd1;
  localparam logic [CmdW-1:0] CMD_START = 3'd2;
  localparam logic [CmdW-1:0] CMD_STOP  = 3'd3;
  localparam logic [CmdW-1:0] CMD_WRITE = 3'd4;
  localparam logic [CmdW-1:0] CMD_READ  = 3'd5;

  localparam logic [1:0] REG_ACK_POLL_LIMIT  = 2'd0;
  localparam logic [1:0] REG_WAKE_IDLE_TICKS = 2'd1;

  localparam logic [7:0]  ACK_POLL_LIMIT_RST  = 8'd250;
  localparam logic [15:0] WAKE_IDLE_TICKS_RST = 16'd4000;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [7:0]      tx_byte;
    logic            send_ack;
    logic            sda_sample;
  } i2cm_in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive_low;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } i2cm_out_t;

  typedef struct packed {
    logic [7:0]  ack_poll_limit;
    logic [15:0] wake_idle_ticks;
  } i2cm_cfg_t;

  typedef enum logic [21:0] {
    PH_IDLE    = 22'h000001,
    PH_WK_HI   = 22'h000002,
    PH_WK_LO   = 22'h000004,
    PH_WK_WAIT = 22'h000008,
    PH_ST_A    = 22'h000010,
    PH_ST_B    = 22'h000020,
    PH_ST_C    = 22'h000040,
    PH_SP_A    = 22'h000080,
    PH_SP_B    = 22'h000100,
    PH_SP_C    = 22'h000200,
    PH_WB_LO   = 22'h000400,
    PH_WB_HI   = 22'h000800,
    PH_WB_TAIL = 22'h001000,
    PH_AK_RISE = 22'h002000,
    PH_AK_POLL = 22'h004000,
    PH_AK_END  = 22'h008000,
    PH_RB_PRE  = 22'h010000,
    PH_RB_HI   = 22'h020000,
    PH_RB_LO   = 22'h040000,
    PH_RA_A    = 22'h080000,
    PH_RA_B    = 22'h100000,
    PH_RA_C    = 22'h200000
  } i2cm_phase_t;

endpackage

`default_nettype wire

@@ hdl/i2c_master_byte_engine.sv @@
// I2C master byte engine, top level.
// Joins the config registers, the bus sequencer and the result register.
// Uses i2cm_pkg, i2cm_regs, i2cm_seq.
//
// Usage: every cmd item is one half-bit tick. It carries the sampled SDA
// level and, when the engine is idle, a command (wake, start, stop, write
// byte, read byte). Each accepted item yields exactly one res item with
// the SCL level and SDA pull-down for that tick, plus ready/done flags,
// the last read byte and the ack error flag.
// Output: the res item is registered and appears in the cycle after its cmd item is taken.
// Throughput: one item per cycle; the result register is reloaded in the
// same cycle it is emptied, so cmd_ready stays high while res flows.
// Stall: while res_valid is high and res_ready low, cmd_ready drops and
// the sequencer state holds; nothing is lost or repeated.
// Config: cfg writes (index 0 ack poll limit, 1 wake idle ticks) are
// always taken; write them only while the engine is idle.
// Reset: SCL released, SDA released, phase idle, registers to defaults.
`default_nettype none

module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire i2cm_in_t    cmd,
  output logic             res_valid,
  input  wire logic        res_ready,
  output i2cm_out_t        res,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  i2cm_cfg_t cfg;
  i2cm_out_t tick_res;
  i2cm_out_t res_reg;
  logic      res_full;
  logic      step;

  assign cmd_ready = !res_full || res_ready;
  assign step      = cmd_valid && cmd_ready;
  assign res_valid = res_full;
  assign res       = res_reg;

  i2cm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i2cm_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (cmd),
    .cfg  (cfg),
    .res  (tick_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (step) begin
      res_full <= 1'b1;
    end else if (res_ready) begin
      res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_reg <= tick_res;
    end
  end

endmodule

`default_nettype wire

@@ hdl/i2cm_regs.sv @@
// I2C master byte engine: configuration register file.
// Holds the ack poll limit and the wake idle length; uses i2cm_pkg.
`default_nettype none

module i2cm_regs
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output i2cm_cfg_t        cfg
);

  i2cm_cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.ack_poll_limit  <= ACK_POLL_LIMIT_RST;
      regs.wake_idle_ticks <= WAKE_IDLE_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ACK_POLL_LIMIT:  regs.ack_poll_limit  <= cfg_data[7:0];
        REG_WAKE_IDLE_TICKS: regs.wake_idle_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/i2cm_seq.sv @@
// I2C master byte engine: bus sequencer.
// Phase register, shift/count state and the per-tick next-state logic;
// runs one phase on each accepted item (from idle, its command's first phase). Uses i2cm_pkg.
`default_nettype none

module i2cm_seq
  import i2cm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire i2cm_in_t  item,
  input  wire i2cm_cfg_t cfg,
  output i2cm_out_t      res
);

  i2cm_phase_t phase, phase_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [15:0] wait_count, wait_count_next;
  logic        scl_reg, scl_reg_next;
  logic        sda_low_reg, sda_low_reg_next;
  logic        error_flag, error_flag_next;
  logic        ack_latch, ack_latch_next;
  logic [7:0]  rx_hold, rx_hold_next;
  logic        ready, done, aerr;

  always_comb begin
    phase_next       = phase;
    bit_index_next   = bit_index;
    shift_reg_next   = shift_reg;
    wait_count_next  = wait_count;
    scl_reg_next     = scl_reg;
    sda_low_reg_next = sda_low_reg;
    error_flag_next  = error_flag;
    ack_latch_next   = ack_latch;
    rx_hold_next     = rx_hold;
    ready            = 1'b0;
    done             = 1'b0;
    aerr             = 1'b0;

    // idle: take the command and run its first phase in this same tick
    if (phase == PH_IDLE) begin
      ready = 1'b1;
      case (item.command)
        CMD_WAKE, CMD_START, CMD_STOP, CMD_WRITE, CMD_READ: begin
          bit_index_next  = '0;
          wait_count_next = '0;
          error_flag_next = 1'b0;
          ack_latch_next  = item.send_ack;
          shift_reg_next  = (item.command == CMD_WRITE) ? item.tx_byte : 8'd0;
          case (item.command)
            CMD_WAKE:  phase_next = PH_WK_HI;
            CMD_START: phase_next = PH_ST_A;
            CMD_STOP:  phase_next = PH_SP_A;
            CMD_WRITE: phase_next = PH_WB_LO;
            default:   phase_next = PH_RB_PRE;
          endcase
        end
        default: ;
      endcase
    end

    case (phase_next)
      PH_WK_HI: begin
        scl_reg_next = 1'b1; sda_low_reg_next = 1'b0; phase_next = PH_WK_LO;
      end
      PH_WK_LO: begin
        scl_reg_next = 1'b0; sda_low_reg_next = 1'b0;
        wait_count_next = '0; phase_next = PH_WK_WAIT;
      end
      PH_WK_WAIT: begin
        scl_reg_next = 1'b1; sda_low_reg_next = 1'b0;
        wait_count_next = wait_count_next + 16'd1;
        // a zero setting finishes on the first tick (count wraps never hits 0 first)
        if (wait_count_next == 16'd0 || wait_count_next >= cfg.wake_idle_ticks) begin
          done = 1'b1; phase_next = PH_IDLE;
        end
      end
      PH_ST_A: begin
        scl_reg_next = 1'b1; sda_low_reg_next = 1'b0; phase_next = PH_ST_B;
      end
      PH_ST_B: begin
        scl_reg_next = 1'b1; sda_low_reg_next = 1'b1; phase_next = PH_ST_C;
      end
      PH_ST_C: begin
        scl_reg_next = 1'b0; sda_low_reg_next = 1'b1;
        done = 1'b1; phase_next = PH_IDLE;
      end
      PH_SP_A: begin
        scl_reg_next = 1'b0; sda_low_reg_next = 1'b1; phase_next = PH_SP_B;
      end
      PH_SP_B: begin
        scl_reg_next = 1'b1; sda_low_reg_next = 1'b1; phase_next = PH_SP_C;
      end
      PH_SP_C: begin
        scl_reg_next = 1'b1; sda_low_reg_next = 1'b0;
        done = 1'b1; aerr = error_flag_next; error_flag_next = 1'b0;
        phase_next = PH_IDLE;
      end
      PH_WB_LO: begin
        scl_reg_next = 1'b0; sda_low_reg_next = ~shift_reg_next[7];
        phase_next = PH_WB_HI;
      end
      PH_WB_HI: begin
        scl_reg_next = 1'b1; sda_low_reg_next = ~shift_reg_next[7];
        shift_reg_next = {shift_reg_next[6:0], 1'b0};
        bit_index_next = bit_index_next + 4'd1;
        phase_next = (bit_index_next >= BITS_PER_BYTE) ? PH_WB_TAIL : PH_WB_LO;
      end
      PH_WB_TAIL: begin
        scl_reg_next = 1'b0; phase_next = PH_AK_RISE;
      end
      PH_AK_RISE: begin
        scl_reg_next = 1'b1; sda_low_reg_next = 1'b0;
        wait_count_next = '0; phase_next = PH_AK_POLL;
      end
      PH_AK_POLL: begin
        scl_reg_next = 1'b1; sda_low_reg_next = 1'b0;
        if (!item.sda_sample) begin
          phase_next = PH_AK_END;
        end else begin
          wait_count_next = wait_count_next + 16'd1;
          if (wait_count_next > {8'd0, cfg.ack_poll_limit}) begin
            error_flag_next = 1'b1; phase_next = PH_SP_A;
          end
        end
      end
      PH_AK_END: begin
        scl_reg_next = 1'b0; sda_low_reg_next = 1'b0;
        done = 1'b1; phase_next = PH_IDLE;
      end
      PH_RB_PRE: begin
        scl_reg_next = 1'b0; sda_low_reg_next = 1'b0; phase_next = PH_RB_HI;
      end
      PH_RB_HI: begin
        scl_reg_next = 1'b1; sda_low_reg_next = 1'b0;
        shift_reg_next = {shift_reg_next[6:0], item.sda_sample};
        bit_index_next = bit_index_next + 4'd1;
        phase_next = PH_RB_LO;
      end
      PH_RB_LO: begin
        scl_reg_next = 1'b0; sda_low_reg_next = 1'b0;
        phase_next = (bit_index_next >= BITS_PER_BYTE) ? PH_RA_A : PH_RB_HI;
      end
      PH_RA_A: begin
        scl_reg_next = 1'b0; sda_low_reg_next = ack_latch_next; phase_next = PH_RA_B;
      end
      PH_RA_B: begin
        scl_reg_next = 1'b1; sda_low_reg_next = ack_latch_next; phase_next = PH_RA_C;
      end
      PH_RA_C: begin
        scl_reg_next = 1'b0; sda_low_reg_next = ack_latch_next;
        rx_hold_next = shift_reg_next;
        done = 1'b1; phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_index   <= '0;
      shift_reg   <= '0;
      wait_count  <= '0;
      scl_reg     <= 1'b1;
      sda_low_reg <= 1'b0;
      error_flag  <= 1'b0;
      ack_latch   <= 1'b0;
      rx_hold     <= '0;
    end else if (step) begin
      phase       <= phase_next;
      bit_index   <= bit_index_next;
      shift_reg   <= shift_reg_next;
      wait_count  <= wait_count_next;
      scl_reg     <= scl_reg_next;
      sda_low_reg <= sda_low_reg_next;
      error_flag  <= error_flag_next;
      ack_latch   <= ack_latch_next;
      rx_hold     <= rx_hold_next;
    end
  end

  always_comb begin
    res.scl_level     = scl_reg_next;
    res.sda_drive_low = sda_low_reg_next;
    res.ready_res     = ready;
    res.done_res      = done;
    res.rx_byte       = rx_hold_next;
    res.ack_error     = aerr;
  end

endmodule

`default_nettype wire
